### rtl/core/pwws_pkg.sv
// pulse width window stats: shared constants, state type and window control struct
// no dependencies; imported by every other file of the block
`default_nettype none

package pwws_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int WLEN_W   = 7;
    localparam int MEAN_W   = 32;
    localparam int MAXO_W   = 24;
    localparam int FRAC_W   = 8;

    // parameter defaults
    localparam int MAX_WINDOW_DEF = 64;
    localparam int COUNT_BITS_DEF = 24;

    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(1);
    localparam logic [MEAN_W-1:0] MEAN_SAT   = {MEAN_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_WAIT,
        S_DONE
    } t_state;

    // per-window control from the sequencer
    typedef struct packed {
        logic push;   // open a new entry at the head
        logic count;  // count the current sample into the head entry
        logic clear;  // restart the sum/max accumulators
        logic scan;   // rotate the chain one place and accumulate
    } t_win_ctrl;

endpackage

`default_nettype wire

### rtl/core/pwws_sample_if.sv
// sample channel: valid/ready handshake carrying one signed sample
// depends on pwws_pkg
`default_nettype none

interface pwws_sample_if import pwws_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

`default_nettype wire

### rtl/core/pwws_stats_if.sv
// stats channel: valid/ready handshake carrying means and maxima per polarity
// depends on pwws_pkg
`default_nettype none

interface pwws_stats_if import pwws_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MEAN_W-1:0] mean_positive;
    logic [MEAN_W-1:0] mean_negative;
    logic [MAXO_W-1:0] max_positive;
    logic [MAXO_W-1:0] max_negative;

    modport source (output valid, output mean_positive, output mean_negative,
                    output max_positive, output max_negative, input ready);
    modport sink   (input valid, input mean_positive, input mean_negative,
                    input max_positive, input max_negative, output ready);
endinterface

`default_nettype wire

### rtl/core/pwws_cell.sv
// one pulse length cell of the window chain
// shifts from the newer neighbor or rotates from the older one; uses pwws_pkg
`default_nettype none

module pwws_cell
    import pwws_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_shift,
    input  wire                   i_rotate,
    input  wire  [COUNT_BITS-1:0] i_from_newer,
    input  wire  [COUNT_BITS-1:0] i_from_older,
    output logic [COUNT_BITS-1:0] o_value
);

    logic [COUNT_BITS-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else if (i_shift) begin
            r_value <= i_from_newer;
        end else if (i_rotate) begin
            r_value <= i_from_older;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

### rtl/core/pwws_window.sv
// one polarity window: chain of length cells, fill count, scan accumulators
// instantiates pwws_cell; uses pwws_pkg
`default_nettype none

module pwws_window
    import pwws_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int EW         = $clog2(MAX_WINDOW + 1),
    parameter int SUM_W      = COUNT_BITS + EW
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  t_win_ctrl       i_ctrl,
    input  wire  [EW-1:0]         i_win,
    output logic [SUM_W-1:0]      o_sum,
    output logic [COUNT_BITS-1:0] o_max
);

    logic [COUNT_BITS-1:0] w_cell [MAX_WINDOW];
    logic [COUNT_BITS-1:0] w_head_next;
    logic [EW-1:0]         r_fill;
    logic [EW-1:0]         n_fill;
    logic [EW-1:0]         r_left;
    logic [SUM_W-1:0]      r_sum;
    logic [COUNT_BITS-1:0] r_max;

    // new entry starts at one since it already holds the current sample
    always_comb begin
        if (i_ctrl.push) begin
            w_head_next = COUNT_BITS'(1);
        end else if (w_cell[0] == {COUNT_BITS{1'b1}}) begin
            w_head_next = w_cell[0];
        end else begin
            w_head_next = w_cell[0] + COUNT_BITS'(1);
        end
    end

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic [COUNT_BITS-1:0] w_newer;
        logic [COUNT_BITS-1:0] w_older;
        logic                  w_shift;

        if (g == 0) begin : g_head
            assign w_newer = w_head_next;
            assign w_shift = i_ctrl.push | i_ctrl.count;
        end else begin : g_body
            assign w_newer = w_cell[g-1];
            assign w_shift = i_ctrl.push;
        end

        if (g == MAX_WINDOW - 1) begin : g_tail
            assign w_older = w_cell[0];
        end else begin : g_mid
            assign w_older = w_cell[g+1];
        end

        pwws_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (w_shift),
            .i_rotate     (i_ctrl.scan),
            .i_from_newer (w_newer),
            .i_from_older (w_older),
            .o_value      (w_cell[g])
        );
    end

    // fill grows on push, trimmed to the window length
    always_comb begin
        n_fill = r_fill;
        if (i_ctrl.push) begin
            if (r_fill < EW'(MAX_WINDOW)) begin
                n_fill = r_fill + EW'(1);
            end
            if (n_fill > i_win) begin
                n_fill = i_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= EW'(1);
            r_left <= '0;
        end else begin
            r_fill <= n_fill;
            if (i_ctrl.clear) begin
                r_left <= n_fill;
            end else if (i_ctrl.scan && r_left != '0) begin
                r_left <= r_left - EW'(1);
            end
        end
    end

    // head cell shows entry k during scan cycle k
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_sum <= '0;
            r_max <= '0;
        end else if (i_ctrl.scan && r_left != '0) begin
            r_sum <= r_sum + SUM_W'(w_cell[0]);
            if (w_cell[0] > r_max) begin
                r_max <= w_cell[0];
            end
        end
    end

    assign o_sum = r_sum;
    assign o_max = r_max;

endmodule

`default_nettype wire

### rtl/core/pwws_div.sv
// restoring divider, one quotient bit per cycle, quotient saturated to 32 bits
// uses pwws_pkg
`default_nettype none

module pwws_div
    import pwws_pkg::*;
#(
    parameter int DW = COUNT_BITS_DEF + $clog2(MAX_WINDOW_DEF + 1) + FRAC_W,
    parameter int EW = $clog2(MAX_WINDOW_DEF + 1)
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire  [DW-1:0]      i_dividend,
    input  wire  [EW-1:0]      i_divisor,
    output logic               o_busy,
    output logic [MEAN_W-1:0]  o_quot
);

    localparam int CW = $clog2(DW + 1);
    localparam int QW = (DW > MEAN_W) ? DW : MEAN_W;

    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [EW-1:0] r_rem;
    logic [EW:0]   w_trial;
    logic [EW:0]   w_diff;
    logic          w_ge;
    logic [QW-1:0] w_q_ext;

    assign w_trial = {r_rem, r_q[DW-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_ge    = (w_trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[DW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[EW-1:0] : w_trial[EW-1:0];
        end
    end

    assign w_q_ext = QW'(r_q);
    assign o_busy  = (r_cnt != '0);
    assign o_quot  = (w_q_ext > QW'(MEAN_SAT)) ? MEAN_SAT : w_q_ext[MEAN_W-1:0];

endmodule

`default_nettype wire

### rtl/core/pulse_width_window_stats.sv
// pulse width window stats, top level: sequencer, two window chains, two dividers
// per sample: the window update, a full rotation of both cell chains, then a bit-serial
//   divide over DW = COUNT_BITS + clog2(MAX_WINDOW+1) + 8 dividend bits
// one sample in flight: the next sample is accepted only after the result is loaded
//   into the output register, which waits while the previous result is stalled
// reset: synchronous active-low; each window holds one zero entry, window_len is 1
`default_nettype none

module pulse_width_window_stats
    import pwws_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [WLEN_W-1:0] i_cfg_wdata,
    pwws_sample_if.sink       i_sample,
    pwws_stats_if.source      o_stats
);

    // width of window length / fill values, and of the running sum
    localparam int EW    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = COUNT_BITS + EW;
    localparam int DW    = SUM_W + FRAC_W;
    localparam int KW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMPW  = (EW > WLEN_W) ? EW : WLEN_W;

    // configuration register
    logic [WLEN_W-1:0] r_window_len;
    logic [CMPW-1:0]   w_wlen_ext;
    logic [EW-1:0]     w_win;

    // sequencer
    t_state        r_state;
    t_state        n_state;
    logic [KW-1:0] r_scan;
    logic          r_prev_pos;
    logic          w_in_xfer;
    logic          w_pos;
    logic          w_neg;
    logic          w_div_start;
    logic          w_out_load;
    t_win_ctrl     w_pos_ctrl;
    t_win_ctrl     w_neg_ctrl;

    // datapath
    logic [SUM_W-1:0]      w_pos_sum;
    logic [SUM_W-1:0]      w_neg_sum;
    logic [COUNT_BITS-1:0] w_pos_max;
    logic [COUNT_BITS-1:0] w_neg_max;
    logic [MEAN_W-1:0]     w_pos_mean;
    logic [MEAN_W-1:0]     w_neg_mean;
    logic                  w_pos_busy;
    logic                  w_neg_busy;

    // output register
    logic              r_out_valid;
    logic [MEAN_W-1:0] r_mean_pos;
    logic [MEAN_W-1:0] r_mean_neg;
    logic [MAXO_W-1:0] r_max_pos;
    logic [MAXO_W-1:0] r_max_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WLEN_RESET;
        end else if (i_cfg_we) begin
            r_window_len <= i_cfg_wdata;
        end
    end

    // effective window: zero reads as one, clamped to the chain length
    assign w_wlen_ext = CMPW'(r_window_len);
    always_comb begin
        if (w_wlen_ext == '0) begin
            w_win = EW'(1);
        end else if (w_wlen_ext > CMPW'(MAX_WINDOW)) begin
            w_win = EW'(MAX_WINDOW);
        end else begin
            w_win = w_wlen_ext[EW-1:0];
        end
    end

    // polarity of the incoming sample; zero counts as negative but opens no entry
    assign w_in_xfer = i_sample.valid & i_sample.ready;
    assign w_pos     = !i_sample.sample_value[SAMPLE_W-1] && (i_sample.sample_value != '0);
    assign w_neg     = i_sample.sample_value[SAMPLE_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pos <= 1'b0;
        end else if (w_in_xfer) begin
            r_prev_pos <= w_pos;
        end
    end

    // the window update happens on the transfer edge itself, then the chains
    // rotate once around while their head cells feed the accumulators
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;

        w_pos_ctrl       = '0;
        w_neg_ctrl       = '0;
        w_pos_ctrl.push  = w_in_xfer & w_pos & !r_prev_pos;
        w_pos_ctrl.count = w_in_xfer & w_pos;
        w_pos_ctrl.clear = w_in_xfer;
        w_neg_ctrl.push  = w_in_xfer & w_neg & r_prev_pos;
        w_neg_ctrl.count = w_in_xfer & !w_pos;
        w_neg_ctrl.clear = w_in_xfer;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                w_pos_ctrl.scan = 1'b1;
                w_neg_ctrl.scan = 1'b1;
                if (r_scan == KW'(MAX_WINDOW - 1)) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                w_div_start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (!w_pos_busy && !w_neg_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || o_stats.ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SCAN) begin
                r_scan <= (r_scan == KW'(MAX_WINDOW - 1)) ? '0 : r_scan + KW'(1);
            end
        end
    end

    assign i_sample.ready = (r_state == S_IDLE);

    // positive and negative pulse windows
    pwws_window #(
        .MAX_WINDOW (MAX_WINDOW),
        .COUNT_BITS (COUNT_BITS),
        .EW         (EW),
        .SUM_W      (SUM_W)
    ) u_pos_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_pos_ctrl),
        .i_win   (w_win),
        .o_sum   (w_pos_sum),
        .o_max   (w_pos_max)
    );

    pwws_window #(
        .MAX_WINDOW (MAX_WINDOW),
        .COUNT_BITS (COUNT_BITS),
        .EW         (EW),
        .SUM_W      (SUM_W)
    ) u_neg_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_neg_ctrl),
        .i_win   (w_win),
        .o_sum   (w_neg_sum),
        .o_max   (w_neg_max)
    );

    // mean = (sum << 8) / window, both polarities in parallel
    pwws_div #(
        .DW (DW),
        .EW (EW)
    ) u_pos_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({w_pos_sum, FRAC_W'(0)}),
        .i_divisor  (w_win),
        .o_busy     (w_pos_busy),
        .o_quot     (w_pos_mean)
    );

    pwws_div #(
        .DW (DW),
        .EW (EW)
    ) u_neg_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({w_neg_sum, FRAC_W'(0)}),
        .i_divisor  (w_win),
        .o_busy     (w_neg_busy),
        .o_quot     (w_neg_mean)
    );

    // output register, frees the sequencer to take the next sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_stats.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_mean_pos <= w_pos_mean;
            r_mean_neg <= w_neg_mean;
            r_max_pos  <= MAXO_W'(w_pos_max);
            r_max_neg  <= MAXO_W'(w_neg_max);
        end
    end

    assign o_stats.valid         = r_out_valid;
    assign o_stats.mean_positive = r_mean_pos;
    assign o_stats.mean_negative = r_mean_neg;
    assign o_stats.max_positive  = r_max_pos;
    assign o_stats.max_negative  = r_max_neg;

endmodule

`default_nettype wire

### rtl/core/pwws_checker.sv
// port-level checker for pulse_width_window_stats, with its bind statement
// depends on pwws_pkg and the top level
`default_nettype none

module pwws_checker
    import pwws_pkg::*;
(
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_in_valid,
    input wire              i_in_ready,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire [MEAN_W-1:0] i_mean_pos,
    input wire [MEAN_W-1:0] i_mean_neg,
    input wire [MAXO_W-1:0] i_max_pos,
    input wire [MAXO_W-1:0] i_max_neg
);

    // one sample in flight: ready drops right after a transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready after transfer");

    // a result never appears the cycle after a sample transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready))
        else $error("result too early");

    // reset empties the output register
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_mean_pos) && $stable(i_mean_neg)
             && $stable(i_max_pos) && $stable(i_max_neg)))
        else $error("stalled result changed");

endmodule

bind pulse_width_window_stats pwws_checker u_pwws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_stats.valid),
    .i_out_ready (o_stats.ready),
    .i_mean_pos  (o_stats.mean_positive),
    .i_mean_neg  (o_stats.mean_negative),
    .i_max_pos   (o_stats.max_positive),
    .i_max_neg   (o_stats.max_negative)
);

`default_nettype wire

### dv/pulse_width_window_stats_test.sv
// testbench for pulse_width_window_stats: drives signed samples and checks every stats transfer
// against an in-bench model of the pulse windows; needs pwws_pkg, pwws_sample_if, pwws_stats_if
// and the block's top level
`default_nettype none

module pulse_width_window_stats_test
    import pwws_pkg::*;
();

    // window geometry and polarity slots
    localparam int WIN_DEPTH = MAX_WINDOW_DEF;
    localparam int POL_POS   = 0;
    localparam int POL_NEG   = 1;
    localparam logic [MAXO_W-1:0] COUNT_SAT = {MAXO_W{1'b1}};

    // run control
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 120;   // idle wait after each drain, longer than one sample's processing
    localparam int HOLD_CYCLES   = 2000;
    localparam int PHASE_ITEMS   = 200;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_pos;
        logic [MEAN_W-1:0] mean_neg;
        logic [MAXO_W-1:0] max_pos;
        logic [MAXO_W-1:0] max_neg;
    } t_pulse_stats;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [WLEN_W-1:0] i_cfg_wdata = '0;

    pwws_sample_if sample_ch ();
    pwws_stats_if  stats_ch ();

    pulse_width_window_stats DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (sample_ch),
        .o_stats     (stats_ch)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // pulse window model: two circular stores of pulse lengths
    // ---------------------------------------------------------------
    logic [MAXO_W-1:0] pulse_lens [2][WIN_DEPTH];
    int unsigned       pulse_fill [2];
    int unsigned       pulse_head [2];
    bit                last_was_positive;
    logic [WLEN_W-1:0] window_len_reg;

    // stimulus queues and bookkeeping
    logic signed [SAMPLE_W-1:0] pending_samples [$];
    t_pulse_stats               expected_stats [$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count  = 0;
    int unsigned cycle_count    = 0;
    int unsigned hold_left      = 0;
    bit          hold_req       = 1'b0;
    bit          gen_positive   = 1'b0;

    // append one sample to the stimulus queue
    function automatic void add_sample(logic signed [SAMPLE_W-1:0] s);
        pending_samples.insert(pending_samples.size(), s);
    endfunction

    // zero-length window setting counts as 1, anything past the store depth as full depth
    function automatic int unsigned effective_window();
        int unsigned w;
        w = window_len_reg;
        if (w == 0) begin
            w = 1;
        end
        if (w > WIN_DEPTH) begin
            w = WIN_DEPTH;
        end
        return w;
    endfunction

    // new zero entry at the head; oldest entries fall off past the window length
    function automatic void open_entry(int pol, int unsigned w);
        pulse_head[pol] = (pulse_head[pol] + 1 >= WIN_DEPTH) ? 0 : pulse_head[pol] + 1;
        pulse_lens[pol][pulse_head[pol]] = '0;
        if (pulse_fill[pol] < WIN_DEPTH) begin
            pulse_fill[pol]++;
        end
        if (pulse_fill[pol] > w) begin
            pulse_fill[pol] = w;
        end
    endfunction

    // sum and peak over the valid entries, newest first; the sum is not trimmed
    // when the window length was lowered since the last push
    function automatic void window_summary(input int pol, input int unsigned w,
                                           output logic [MEAN_W-1:0] avg,
                                           output logic [MAXO_W-1:0] peak);
        longint unsigned total;
        longint unsigned quot;
        int unsigned     idx;
        total = 0;
        peak  = '0;
        idx   = pulse_head[pol];
        for (int k = 0; k < pulse_fill[pol]; k++) begin
            total += pulse_lens[pol][idx];
            if (pulse_lens[pol][idx] > peak) begin
                peak = pulse_lens[pol][idx];
            end
            idx = (idx == 0) ? WIN_DEPTH - 1 : idx - 1;
        end
        quot = (total << FRAC_W) / w;
        avg  = (quot > MEAN_SAT) ? MEAN_SAT : quot[MEAN_W-1:0];
    endfunction

    // one sample in, the stats it produces out
    function automatic t_pulse_stats step_pulse_stats(logic signed [SAMPLE_W-1:0] s);
        bit           is_pos;
        bit           is_neg;
        int unsigned  w;
        int           pol;
        t_pulse_stats r;
        logic [MEAN_W-1:0] avg_p, avg_n;
        logic [MAXO_W-1:0] pk_p, pk_n;
        is_pos = (s > 0);
        is_neg = (s < 0);
        w = effective_window();
        // zero after a positive pulse opens nothing and extends the newest negative entry
        if (is_pos != last_was_positive) begin
            if (is_pos) begin
                open_entry(POL_POS, w);
            end else if (is_neg) begin
                open_entry(POL_NEG, w);
            end
        end
        pol = is_pos ? POL_POS : POL_NEG;
        if (pulse_lens[pol][pulse_head[pol]] != COUNT_SAT) begin
            pulse_lens[pol][pulse_head[pol]]++;
        end
        last_was_positive = is_pos;
        window_summary(POL_POS, w, avg_p, pk_p);
        window_summary(POL_NEG, w, avg_n, pk_n);
        r.mean_pos = avg_p;
        r.mean_neg = avg_n;
        r.max_pos  = pk_p;
        r.max_neg  = pk_n;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // a sample of the given polarity, extremes now and then; zero counts as negative
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(bit positive);
        int v;
        if (positive) begin
            case ($urandom_range(9))
                0: v = 32767;
                1: v = 1;
                default: v = $urandom_range(32767, 1);
            endcase
        end else begin
            case ($urandom_range(9))
                0: v = 0;
                1: v = -32768;
                2: v = -1;
                default: v = -int'($urandom_range(32768, 1));
            endcase
        end
        return SAMPLE_W'(v);
    endfunction

    // mostly alternating pulses of random length, some repeats and some raw noise
    task automatic queue_pulses(int n_items);
        int cnt;
        int plen;
        cnt = 0;
        while (cnt < n_items) begin
            if ($urandom_range(99) < 10) begin
                add_sample(SAMPLE_W'($urandom));
                cnt++;
            end else begin
                if ($urandom_range(99) >= 15) begin
                    gen_positive = !gen_positive;
                end
                plen = ($urandom_range(9) == 0) ? $urandom_range(300, 20) : $urandom_range(8, 1);
                for (int k = 0; k < plen && cnt < n_items; k++) begin
                    add_sample(pick_sample(gen_positive));
                    cnt++;
                end
            end
        end
    endtask

    // block is idle once the queue is empty, nothing is offered and every result is back
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_samples.size() != 0 || sample_ch.valid ||
                   expected_stats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_len(logic [WLEN_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        window_len_reg  = v;
    endtask

    // one phase: new window length, idle mix, a short run of the current polarity
    // so a lowered length shows its untrimmed sum, then random pulses and an optional long stall
    task automatic run_phase(logic [WLEN_W-1:0] wlen, int unsigned send_pct,
                             int unsigned recv_pct, bit long_hold);
        write_window_len(wlen);
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        gen_positive   = last_was_positive;
        repeat (3) add_sample(pick_sample(last_was_positive));
        queue_pulses(PHASE_ITEMS);
        if (long_hold) begin
            // stall the output while the sender keeps offering samples
            hold_req = 1'b1;
            @(negedge i_clk);
            hold_req = 1'b0;
        end
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // sample driver: predicts at each accepted transfer
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_ch.valid        <= 1'b0;
            sample_ch.sample_value <= '0;
        end else begin
            if (sample_ch.valid && sample_ch.ready) begin
                expected_stats.insert(expected_stats.size(),
                                      step_pulse_stats(sample_ch.sample_value));
                accepted_count++;
            end
            if (!sample_ch.valid || sample_ch.ready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    sample_ch.valid        <= 1'b1;
                    sample_ch.sample_value <= pending_samples.pop_front();
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stats monitor and ready generation
    // ---------------------------------------------------------------
    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pulse_stats want;
        if (!i_rst_n) begin
            stats_ch.ready <= 1'b0;
        end else begin
            if (stats_ch.valid && stats_ch.ready) begin
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected stats transfer, expected none, actual %h %h %h %h",
                             $time, stats_ch.mean_positive, stats_ch.mean_negative,
                             stats_ch.max_positive, stats_ch.max_negative);
                    error_count++;
                end else begin
                    want = expected_stats.pop_front();
                    check_field("mean_positive", want.mean_pos, stats_ch.mean_positive);
                    check_field("mean_negative", want.mean_neg, stats_ch.mean_negative);
                    check_field("max_positive", want.max_pos, stats_ch.max_positive);
                    check_field("max_negative", want.max_neg, stats_ch.max_negative);
                    checked_count++;
                end
            end
            stats_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_stats.size());
            $display("pulse_width_window_stats_test: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    // sign extremes, zero after positive, single-sample pulses, repeated polarity
    logic signed [SAMPLE_W-1:0] directed_samples [20] = '{
        0, -1, -32768, 1, 32767, 32767, 0, 0, -5, -32768,
        256, 0, -1, 1, -1, 1, 0, 1, 0, -1
    };

    initial begin
        // model reset state: one zero entry per window, length register 1
        foreach (pulse_lens[p, k]) begin
            pulse_lens[p][k] = '0;
        end
        pulse_fill        = '{1, 1};
        pulse_head        = '{0, 0};
        last_was_positive = 1'b0;
        window_len_reg    = WLEN_RESET;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed samples at the reset window length, no idling
        @(negedge i_clk);
        foreach (directed_samples[k]) begin
            add_sample(directed_samples[k]);
        end
        wait_drained();

        // length settings: full, lowered, zero, all ones, past depth, random, minimum
        run_phase(7'd64, 0, 0, 1'b0);
        run_phase(7'd3, 64, 0, 1'b0);
        run_phase(7'd0, 0, 64, 1'b0);
        run_phase(7'd127, 29, 29, 1'b0);
        run_phase(7'd65, 0, 0, 1'b1);
        run_phase(WLEN_W'($urandom_range(63, 2)), 64, 0, 1'b0);
        run_phase(7'd1, 0, 64, 1'b0);

        $display("covered %0d samples and %0d stats transfers over 8 phases,", accepted_count,
                 checked_count);
        $display("window lengths 0, 1, 3, 64, 65, 127 and one random, with a %0d-cycle stall",
                 HOLD_CYCLES);
        if (error_count == 0 && expected_stats.size() == 0) begin
            $display("pulse_width_window_stats_test: done, clean");
        end else begin
            $display("pulse_width_window_stats_test: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/core/pwws_pkg.sv
rtl/core/pwws_sample_if.sv
rtl/core/pwws_stats_if.sv
rtl/core/pwws_cell.sv
rtl/core/pwws_window.sv
rtl/core/pwws_div.sv
rtl/core/pulse_width_window_stats.sv
rtl/core/pwws_checker.sv
dv/pulse_width_window_stats_test.sv
